// File: rtl/nfca_pkg.sv
// ----------------------------------------------------------------------------
// nfca_pkg
// Shared sizes, codes and field widths of the next-fit cell allocator.
// ----------------------------------------------------------------------------
package nfca_pkg;

  localparam int CELLS  = 1024;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = ADDR_W + 1;
  localparam int SIZE_W = 11;
  localparam int TAG_W  = 8;
  localparam int CFG_W  = 11;
  localparam int PTR_W  = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 2;

  localparam logic [TAG_W-1:0] EMPTY_TAG    = 8'hFF;
  localparam logic [CFG_W-1:0] MEM_SIZE_RST = 11'd1024;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

// File: rtl/nfca_req_if.sv
// ----------------------------------------------------------------------------
// nfca_req_if
// Request channel: allocate or release beat with valid/ready.
// ----------------------------------------------------------------------------
interface nfca_req_if;

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [nfca_pkg::TAG_W-1:0]    owner_id;
  logic [nfca_pkg::SIZE_W-1:0]   request_size;

  modport source (output valid, output action, output owner_id, output request_size,
                  input ready);
  modport sink   (input valid, input action, input owner_id, input request_size,
                  output ready);

endinterface

// File: rtl/nfca_rsp_if.sv
// ----------------------------------------------------------------------------
// nfca_rsp_if
// Result channel: status and owner cell count with valid/ready.
// ----------------------------------------------------------------------------
interface nfca_rsp_if;

  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [nfca_pkg::SIZE_W-1:0]   owned_count;

  modport source (output valid, output ok, output owned_count, input ready);
  modport sink   (input valid, input ok, input owned_count, output ready);

endinterface

// File: rtl/next_fit_cell_allocator.sv
// ----------------------------------------------------------------------------
// next_fit_cell_allocator
// Cell map of owner tags with next-fit window allocation and per-owner release.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req       in   valid/ready        action, owner_id, request_size
//  rsp       out  valid/ready        ok, owned_count
//  cfg       in   cfg_we_i           cfg_wdata_i (mem_size)
//
//  One request at a time. Allocate: a setup state, one probe of the cell
//  memory per cycle (up to mem_size probes), a pass over mem_size cells that
//  tags the window and counts the owner's cells, then the result load.
//  Release: the setup state, a pass that frees the owner's cells, the load.
//  After reset all 1024 cells are swept to empty, one cell a cycle, with
//  req.ready low. The result register holds a beat while rsp stalls; the next
//  request is taken as soon as the previous one has been loaded.
// ----------------------------------------------------------------------------
module next_fit_cell_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nfca_pkg::CFG_W-1:0] cfg_wdata_i,
  nfca_req_if.sink                   req,
  nfca_rsp_if.source                 rsp
);
  import nfca_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_PASS,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   mem_size_q, mem_size_d;
  logic               act_q, act_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [SIZE_W-1:0]  sz_q, sz_d;
  logic [PTR_W-1:0]   ns_q, ns_d;
  logic [PTR_W-1:0]   i_q, i_d;
  logic [PTR_W-1:0]   start_q, start_d;
  logic [PTR_W-1:0]   mx_q, mx_d;
  logic [CNT_W-1:0]   probes_q, probes_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [ADDR_W-1:0]  kp_q, kp_d;
  logic               rv_q, rv_d;
  logic               win_q, win_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               res_ok_q, res_ok_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_ok_d;
  logic [SIZE_W-1:0]  out_cnt_q, out_cnt_d;

  logic [TAG_W-1:0]   cell_mem [CELLS];
  logic [TAG_W-1:0]   rdata_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [TAG_W-1:0]   mem_wdata;

  logic [CNT_W-1:0]   tot;
  logic [PTR_W-1:0]   tot_ext;
  logic [PTR_W-1:0]   sz_ext;
  logic [PTR_W-1:0]   nm;
  logic               occ;
  logic [PTR_W-1:0]   c_i, c_start, c_mx;
  logic [PTR_W-1:0]   w_i, w_start, w_mx;
  logic               hit, wrap, bound;
  logic [CNT_W-1:0]   probes_nx;
  logic               limit;
  logic               in_win;

  // clamp mem_size to 1..CELLS
  always_comb begin
    if (mem_size_q == '0) begin
      tot = CNT_W'(1);
    end else if (int'(mem_size_q) > CELLS) begin
      tot = CNT_W'(CELLS);
    end else begin
      tot = CNT_W'(mem_size_q);
    end
  end

  // one next-fit iteration: jump or advance, then wrap and bound checks
  always_comb begin
    tot_ext   = PTR_W'(tot);
    sz_ext    = PTR_W'(sz_q);
    nm        = mx_q + sz_ext;
    occ       = (rdata_q != EMPTY_TAG);
    probes_nx = probes_q + CNT_W'(1);
    limit     = (probes_nx >= tot);
    if (state_q == ST_START) begin
      c_i     = ns_q;
      c_start = ns_q;
      c_mx    = ns_q + sz_ext;
    end else if (occ) begin
      if (nm < tot_ext) begin
        c_i     = mx_q;
        c_start = mx_q;
        c_mx    = nm;
      end else begin
        c_i     = '0;
        c_start = '0;
        c_mx    = sz_ext;
      end
    end else begin
      c_i     = i_q + PTR_W'(1);
      c_start = start_q;
      c_mx    = mx_q;
    end
    hit     = (c_i == c_mx);
    wrap    = (c_mx >= tot_ext);
    w_i     = wrap ? '0 : c_i;
    w_start = wrap ? '0 : c_start;
    w_mx    = wrap ? sz_ext : c_mx;
    bound   = (w_i >= PTR_W'(CELLS));
    in_win  = win_q && (PTR_W'(kp_q) >= start_q) && (PTR_W'(kp_q) < mx_q);
  end

  always_comb begin
    state_d     = state_q;
    mem_size_d  = cfg_we_i ? cfg_wdata_i : mem_size_q;
    act_d       = act_q;
    tag_d       = tag_q;
    sz_d        = sz_q;
    ns_d        = ns_q;
    i_d         = i_q;
    start_d     = start_q;
    mx_d        = mx_q;
    probes_d    = probes_q;
    k_d         = k_q;
    kp_d        = kp_q;
    rv_d        = rv_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    res_ok_d    = res_ok_q;
    out_valid_d = out_valid_q && !rsp.ready;
    out_ok_d    = out_ok_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = kp_q;
    mem_wdata   = EMPTY_TAG;
    mem_raddr   = w_i[ADDR_W-1:0];

    unique case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[ADDR_W-1:0];
        k_d       = k_q + CNT_W'(1);
        if (k_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          act_d   = req.action;
          tag_d   = req.owner_id;
          sz_d    = req.request_size;
          state_d = ST_START;
        end
      end
      ST_START, ST_SCAN: begin
        k_d   = '0;
        rv_d  = 1'b0;
        cnt_d = '0;
        win_d = 1'b0;
        probes_d = (state_q == ST_START) ? '0 : probes_nx;
        priority if (state_q == ST_START && tag_q == EMPTY_TAG) begin
          res_ok_d = (act_q == ACT_RELEASE);
          state_d  = ST_DONE;
        end else if (state_q == ST_START && act_q == ACT_RELEASE) begin
          state_d = ST_PASS;
        end else if (state_q == ST_SCAN && limit) begin
          state_d = ST_PASS;
        end else if (hit) begin
          win_d   = 1'b1;
          start_d = c_start;
          mx_d    = c_mx;
          ns_d    = c_mx;
          state_d = ST_PASS;
        end else if (bound) begin
          state_d = ST_PASS;
        end else begin
          i_d     = w_i;
          start_d = w_start;
          mx_d    = w_mx;
          state_d = ST_SCAN;
        end
      end
      ST_PASS: begin
        mem_raddr = k_q[ADDR_W-1:0];
        if (k_q < tot) begin
          k_d  = k_q + CNT_W'(1);
          kp_d = k_q[ADDR_W-1:0];
          rv_d = 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          if (act_q == ACT_RELEASE) begin
            if (rdata_q == tag_q) begin
              mem_we = 1'b1;
            end
          end else if (in_win) begin
            mem_we    = 1'b1;
            mem_wdata = tag_q;
            cnt_d     = cnt_q + CNT_W'(1);
          end else if (rdata_q == tag_q) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        if (k_q >= tot && !rv_q) begin
          res_ok_d = (act_q == ACT_RELEASE) || win_q;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d = 1'b1;
          out_ok_d    = res_ok_q;
          out_cnt_d   = SIZE_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      mem_size_q  <= MEM_SIZE_RST;
      act_q       <= ACT_ALLOC;
      tag_q       <= EMPTY_TAG;
      sz_q        <= '0;
      ns_q        <= '0;
      i_q         <= '0;
      start_q     <= '0;
      mx_q        <= '0;
      probes_q    <= '0;
      k_q         <= '0;
      kp_q        <= '0;
      rv_q        <= 1'b0;
      win_q       <= 1'b0;
      cnt_q       <= '0;
      res_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      mem_size_q  <= mem_size_d;
      act_q       <= act_d;
      tag_q       <= tag_d;
      sz_q        <= sz_d;
      ns_q        <= ns_d;
      i_q         <= i_d;
      start_q     <= start_d;
      mx_q        <= mx_d;
      probes_q    <= probes_d;
      k_q         <= k_d;
      kp_q        <= kp_d;
      rv_q        <= rv_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      res_ok_q    <= res_ok_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_cnt_q   <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cell_mem[mem_raddr];
  end

  assign req.ready       = (state_q == ST_IDLE);
  assign rsp.valid       = out_valid_q;
  assign rsp.ok          = out_ok_q;
  assign rsp.owned_count = out_cnt_q;

  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("cell write during window search");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q < PTR_W'(CELLS)))
    else $error("probe address beyond cell store");

  a_ptr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ns_q < PTR_W'(CELLS))
    else $error("roving pointer beyond cell store");

  a_pass_write_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS && mem_we) |-> rv_q)
    else $error("pass write without read data");

  a_release_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS && act_q == ACT_RELEASE) |-> (cnt_q == '0))
    else $error("release counted owner cells");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the next-fit cell allocator. A queue-fed driver
// offers allocate and release beats in bursts; a monitor compares each result
// beat with a cycle-free prediction of the cell map, the roving pointer and
// the owner counts. The cell-count register is swept across several settings,
// the clamped extremes among them, and the receiver stalls on its own pattern
// with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import nfca_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD   = 2500;
  localparam int SETTLE      = 2100;

  typedef struct packed {
    logic              action;
    logic [TAG_W-1:0]  owner_id;
    logic [SIZE_W-1:0] request_size;
  } req_beat_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] owned_count;
  } rsp_beat_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  nfca_req_if req_bus ();
  nfca_rsp_if rsp_bus ();

  next_fit_cell_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_bus),
    .rsp         (rsp_bus)
  );

  // predicted block state
  logic [TAG_W-1:0] cell_tag [CELLS];
  int unsigned      rover = 0;
  logic [CFG_W-1:0] mem_size_cfg = MEM_SIZE_RST;

  req_beat_t   pending_reqs [$];
  rsp_beat_t   expected_rsps [$];
  int unsigned errors = 0;
  int unsigned n_granted = 0;
  int unsigned n_refused = 0;
  int unsigned n_released = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 1;
  int unsigned cycle_cnt = 0;

  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic rsp_beat_t apply_request(req_beat_t r);
    int unsigned span, win_end, win_start, probe, probes, jump, k, tally;
    bit          done;
    rsp_beat_t   res;
    span = (mem_size_cfg == 0) ? 1 : ((mem_size_cfg > CELLS) ? CELLS : mem_size_cfg);
    res.ok = 1'b1;
    if (r.action == ACT_ALLOC) begin
      res.ok = 1'b0;
      win_end = rover + r.request_size;
      win_start = rover;
      probe = rover;
      probes = 0;
      done = (r.owner_id == EMPTY_TAG);
      while (!done) begin
        if (probe == win_end) begin
          for (k = win_start; k < win_end && k < CELLS; k++) cell_tag[k] = r.owner_id;
          rover = win_end;
          res.ok = 1'b1;
          done = 1'b1;
        end else begin
          if (win_end >= span) begin
            probe = 0;
            win_start = 0;
            win_end = r.request_size;
          end
          if (probe >= CELLS) begin
            done = 1'b1;
          end else begin
            if (cell_tag[probe] != EMPTY_TAG) begin
              jump = win_end + r.request_size;
              if (jump < span) begin
                probe = win_end;
                win_start = win_end;
                win_end = jump;
              end else begin
                probe = 0;
                win_start = 0;
                win_end = r.request_size;
              end
            end else begin
              probe++;
            end
            probes++;
            if (probes >= span) done = 1'b1;
          end
        end
      end
    end else if (r.owner_id != EMPTY_TAG) begin
      for (k = 0; k < span; k++)
        if (cell_tag[k] == r.owner_id) cell_tag[k] = EMPTY_TAG;
    end
    tally = 0;
    if (r.owner_id != EMPTY_TAG)
      for (k = 0; k < span; k++)
        if (cell_tag[k] == r.owner_id) tally++;
    res.owned_count = tally[SIZE_W-1:0];
    return res;
  endfunction

  // driver: bursts of beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    req_beat_t   nxt;
    rsp_beat_t   pred;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_ALLOC;
      req_bus.owner_id     <= '0;
      req_bus.request_size <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        pred = apply_request({req_bus.action, req_bus.owner_id, req_bus.request_size});
        expected_rsps = {expected_rsps, pred};
        if (req_bus.action == ACT_RELEASE) n_released++;
        else if (pred.ok) n_granted++;
        else n_refused++;
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs[0];
          pending_reqs.delete(0);
          req_bus.valid        <= 1'b1;
          req_bus.action       <= nxt.action;
          req_bus.owner_id     <= nxt.owner_id;
          req_bus.request_size <= nxt.request_size;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin : stall_results
    int unsigned stall_mode;
    int unsigned mode_left;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        rsp_bus.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          2:       rsp_bus.ready <= ($urandom_range(0, 7) == 0);
          default: rsp_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check_results
    rsp_beat_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result beat: ok=%0d owned_count=%0d",
               rsp_bus.ok, rsp_bus.owned_count);
        errors++;
      end else begin
        want = expected_rsps[0];
        expected_rsps.delete(0);
        n_checked++;
        if (rsp_bus.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, rsp_bus.ok);
          errors++;
        end
        if (rsp_bus.owned_count !== want.owned_count) begin
          $error("owned_count: expected %0d, actual %0d",
                 want.owned_count, rsp_bus.owned_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_req(input logic act, input logic [TAG_W-1:0] owner,
                           input logic [SIZE_W-1:0] size);
    req_beat_t beat;
    beat = {act, owner, size};
    pending_reqs = {pending_reqs, beat};
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_bus.valid || expected_rsps.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] size_cfg, input int n_items,
                           input bit with_hold);
    int unsigned span, pick;
    logic        act;
    logic [TAG_W-1:0]  owner;
    logic [SIZE_W-1:0] size;
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size_cfg;
    mem_size_cfg = size_cfg;
    n_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (with_hold) hold_req <= 1'b1;
    span = (size_cfg == 0) ? 1 : ((size_cfg > CELLS) ? CELLS : size_cfg);
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 19);
      if (pick < 16) owner = TAG_W'($urandom_range(0, 5));
      else if (pick < 19) owner = TAG_W'($urandom_range(0, 254));
      else owner = TAG_W'($urandom_range(0, 255));
      act = ($urandom_range(0, 99) < 30) ? ACT_RELEASE : ACT_ALLOC;
      pick = $urandom_range(0, 19);
      if (act == ACT_RELEASE || pick == 19) size = SIZE_W'($urandom_range(0, 2047));
      else if (pick == 0) size = '0;
      else if (pick < 15) size = SIZE_W'($urandom_range(1, (span < 4) ? 1 : span / 4));
      else if (pick < 18) size = SIZE_W'($urandom_range(span / 4, span + 1));
      else size = SIZE_W'(span);
      queue_req(act, owner, size);
    end
    wait_idle();
  endtask

  initial begin
    for (int k = 0; k < CELLS; k++) cell_tag[k] = EMPTY_TAG;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(ACT_ALLOC,   8'd0,      11'd0);
    queue_req(ACT_ALLOC,   8'd1,      11'd1);
    queue_req(ACT_ALLOC,   8'd254,    11'd1000);
    queue_req(ACT_ALLOC,   8'd2,      11'd30);
    queue_req(ACT_ALLOC,   EMPTY_TAG, 11'd5);
    queue_req(ACT_RELEASE, EMPTY_TAG, 11'd0);
    queue_req(ACT_ALLOC,   8'd3,      11'd1024);
    queue_req(ACT_ALLOC,   8'd7,      11'd2047);
    queue_req(ACT_RELEASE, 8'd254,    11'd2047);
    queue_req(ACT_RELEASE, 8'd1,      11'd0);
    queue_req(ACT_RELEASE, 8'd0,      11'd0);
    queue_req(ACT_ALLOC,   8'd3,      11'd1024);
    queue_req(ACT_ALLOC,   8'd4,      11'd1023);
    queue_req(ACT_ALLOC,   8'hAA,     11'h555);
    queue_req(ACT_ALLOC,   8'h55,     11'h2AA);
    queue_req(ACT_RELEASE, 8'd4,      11'd0);
    queue_req(ACT_ALLOC,   8'h55,     11'd1);
    queue_req(ACT_RELEASE, 8'hAA,     11'h7FF);
    wait_idle();

    run_phase(11'd1,    15,  1'b0);
    run_phase(11'd0,    10,  1'b0);
    run_phase(11'd2,    20,  1'b0);
    run_phase(11'd16,   80,  1'b1);
    run_phase(11'd2047, 20,  1'b0);
    run_phase(11'd48,   100, 1'b0);
    run_phase(11'd33,   80,  1'b0);
    run_phase(11'd128,  80,  1'b0);
    run_phase(11'd7,    50,  1'b0);
    run_phase(11'd64,   100, 1'b0);

    repeat (SETTLE) @(posedge clk_i);
    $display("Covered %0d allocates (%0d granted, %0d refused) and %0d releases",
             n_granted + n_refused, n_granted, n_refused, n_released);
    $display("over %0d cell-count settings; %0d result beats checked, %0d errors",
             n_settings, n_checked, errors);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
